>>> rtl/core/quaternion_rotation_unit_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion rotation unit
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATION_UNIT_TOP_MACROS_SVH
`define QUATERNION_ROTATION_UNIT_TOP_MACROS_SVH
`ifndef SYNTH
`define QRU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define QRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QRU_ASSERT_IMPLY(lbl, ante, cons, msg)
`define QRU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/qru_pkg.sv
// ----------------------------------------------------------------------------
// qru_pkg
// Widths, constants and stage types of the quaternion rotation unit.
// ----------------------------------------------------------------------------
package qru_pkg;

  localparam int QW     = 16;
  localparam int FRAC   = 14;
  localparam int CFG_W  = 32;
  localparam int SQ_W   = 32;
  localparam int NORM_W = 33;
  localparam int M1_W   = 32;
  localparam int T_W    = 34;
  localparam int M3_W   = 50;
  localparam int P_W    = 52;
  localparam int MAG_W  = 51;
  localparam int NUM_W  = 53;
  localparam int D_W    = 34;
  localparam int QB     = 16;
  localparam int HI_W   = NUM_W - QB;

  localparam logic [CFG_W-1:0]  MIN_NORM_RESET = 32'd2684;
  localparam logic [NORM_W-1:0] DEGEN_DEN      = NORM_W'(2 ** FRAC);
  localparam logic [QB-1:0]     POS_MAX        = 16'd32767;
  localparam logic [QB-1:0]     NEG_MAG        = 16'd32768;

  // Hamilton product term signs, out[k] += sign * a[i] * b[k^i], bit i of entry k
  localparam logic [3:0] QSIGN [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  typedef logic signed [QW-1:0] q16_t;

  typedef struct {
    logic             valid;
    logic             degen;
    logic [D_W-1:0]   d;
    logic [NUM_W-1:0] num [4];
    logic             neg [4];
  } div_in_t;

  typedef struct {
    logic           valid;
    logic           degen;
    logic [D_W-1:0] d;
    logic [D_W-1:0] rem [4];
    logic [QB-1:0]  lo  [4];
    logic [QB-1:0]  q   [4];
    logic           neg [4];
    logic           ovf [4];
  } div_stage_t;

  typedef struct {
    logic valid;
    logic degen;
    logic sat;
    q16_t res [4];
  } div_out_t;

endpackage

>>> rtl/core/qru_cfg_if.sv
// ----------------------------------------------------------------------------
// qru_cfg_if
// Threshold register write channel.
// ----------------------------------------------------------------------------
interface qru_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [qru_pkg::CFG_W-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/qru_in_if.sv
// ----------------------------------------------------------------------------
// qru_in_if
// Request channel: rotation and subject quaternions.
// ----------------------------------------------------------------------------
interface qru_in_if;
  logic          valid;
  logic          ready;
  qru_pkg::q16_t rot_w, rot_x, rot_y, rot_z;
  qru_pkg::q16_t subj_w, subj_x, subj_y, subj_z;
  modport source (output valid, output rot_w, output rot_x, output rot_y, output rot_z,
                  output subj_w, output subj_x, output subj_y, output subj_z, input ready);
  modport sink (input valid, input rot_w, input rot_x, input rot_y, input rot_z,
                input subj_w, input subj_x, input subj_y, input subj_z, output ready);
endinterface

>>> rtl/core/qru_out_if.sv
// ----------------------------------------------------------------------------
// qru_out_if
// Result channel: rotated quaternion and flags.
// ----------------------------------------------------------------------------
interface qru_out_if;
  logic          valid;
  logic          ready;
  qru_pkg::q16_t res_w, res_x, res_y, res_z;
  logic          degenerate;
  logic          saturated;
  modport source (output valid, output res_w, output res_x, output res_y, output res_z,
                  output degenerate, output saturated, input ready);
  modport sink (input valid, input res_w, input res_x, input res_y, input res_z,
                input degenerate, input saturated, output ready);
endinterface

>>> rtl/core/qru_prod.sv
// ----------------------------------------------------------------------------
// qru_prod
// Four-stage product pipeline: norm, s*conj(r), r*t, dividend and divisor.
// ----------------------------------------------------------------------------
module qru_prod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  qru_pkg::q16_t             rot  [4],
  input  qru_pkg::q16_t             subj [4],
  input  logic [qru_pkg::CFG_W-1:0] thr,
  output qru_pkg::div_in_t          dout
);

  // stage 1
  logic                             v1;
  qru_pkg::q16_t                    r1 [4];
  qru_pkg::q16_t                    s1 [4];
  logic [qru_pkg::SQ_W-1:0]         sq1 [4];
  logic signed [qru_pkg::M1_W-1:0]  m1 [4][4];

  // stage 2
  logic                             v2;
  qru_pkg::q16_t                    r2 [4];
  logic signed [qru_pkg::T_W-1:0]   t2 [4];
  logic [qru_pkg::NORM_W-1:0]       den2;
  logic                             degen2;

  logic [qru_pkg::NORM_W-1:0]       n2;
  logic signed [qru_pkg::T_W-1:0]   t_sum [4];
  logic signed [qru_pkg::T_W-1:0]   t_next [4];
  logic                             degen_next;

  // stage 3
  logic                             v3;
  logic signed [qru_pkg::M3_W-1:0]  m3 [4][4];
  logic [qru_pkg::NORM_W-1:0]       den3;
  logic                             degen3;

  // stage 4
  logic signed [qru_pkg::P_W-1:0]   p_sum [4];
  qru_pkg::div_in_t                 dout_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        r1[i]  <= rot[i];
        s1[i]  <= subj[i];
        sq1[i] <= qru_pkg::SQ_W'(rot[i]) * qru_pkg::SQ_W'(rot[i]);
      end
      for (int k = 0; k < 4; k++) begin
        for (int a = 0; a < 4; a++) begin
          m1[k][a] <= qru_pkg::M1_W'(subj[a]) * qru_pkg::M1_W'(rot[k ^ a]);
        end
      end
    end
  end

  always_comb begin
    n2 = '0;
    for (int i = 0; i < 4; i++) begin
      n2 = n2 + qru_pkg::NORM_W'(sq1[i]);
    end
    for (int k = 0; k < 4; k++) begin
      t_sum[k] = '0;
      for (int a = 0; a < 4; a++) begin
        // conj(r) flips every term whose r index is imaginary
        if (qru_pkg::QSIGN[k][a] ^ ((k ^ a) != 0)) begin
          t_sum[k] = t_sum[k] - qru_pkg::T_W'(m1[k][a]);
        end else begin
          t_sum[k] = t_sum[k] + qru_pkg::T_W'(m1[k][a]);
        end
      end
    end
    degen_next = (n2 == '0) || (n2 < qru_pkg::NORM_W'(thr));
    for (int k = 0; k < 4; k++) begin
      t_next[k] = degen_next ? qru_pkg::T_W'(s1[k]) : t_sum[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2     <= r1;
      t2     <= t_next;
      den2   <= degen_next ? qru_pkg::DEGEN_DEN : n2;
      degen2 <= degen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int a = 0; a < 4; a++) begin
          m3[k][a] <= qru_pkg::M3_W'(r2[a]) * qru_pkg::M3_W'(t2[k ^ a]);
        end
      end
      den3   <= den2;
      degen3 <= degen2;
    end
  end

  always_comb begin
    dout_next.valid = v3;
    dout_next.degen = degen3;
    dout_next.d     = qru_pkg::D_W'({den3, 1'b0});
    for (int k = 0; k < 4; k++) begin
      p_sum[k] = '0;
      for (int a = 0; a < 4; a++) begin
        if (qru_pkg::QSIGN[k][a]) begin
          p_sum[k] = p_sum[k] - qru_pkg::P_W'(m3[k][a]);
        end else begin
          p_sum[k] = p_sum[k] + qru_pkg::P_W'(m3[k][a]);
        end
      end
      dout_next.neg[k] = p_sum[k][qru_pkg::P_W-1];
      // round half away: (2*|p| + den) / (2*den)
      dout_next.num[k] = qru_pkg::NUM_W'({qru_pkg::MAG_W'(p_sum[k][qru_pkg::P_W-1] ?
                                                           -p_sum[k] : p_sum[k]), 1'b0})
                         + qru_pkg::NUM_W'(den3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

>>> rtl/core/qru_div_step.sv
// ----------------------------------------------------------------------------
// qru_div_step
// One restoring division step, one quotient bit per lane.
// ----------------------------------------------------------------------------
module qru_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  qru_pkg::div_stage_t din,
  output qru_pkg::div_stage_t dout
);

  qru_pkg::div_stage_t dout_next;

  always_comb begin
    logic [qru_pkg::D_W:0] sh;
    logic                  take;
    dout_next = din;
    for (int k = 0; k < 4; k++) begin
      sh   = {din.rem[k], din.lo[k][qru_pkg::QB-1]};
      take = sh >= {1'b0, din.d};
      dout_next.rem[k] = take ? qru_pkg::D_W'(sh - {1'b0, din.d}) : qru_pkg::D_W'(sh);
      dout_next.lo[k]  = din.lo[k] << 1;
      dout_next.q[k]   = {din.q[k][qru_pkg::QB-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

>>> rtl/core/qru_div.sv
// ----------------------------------------------------------------------------
// qru_div
// Pipelined rounding divider: overflow check, 16 bit steps, saturation.
// ----------------------------------------------------------------------------
module qru_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  qru_pkg::div_in_t  din,
  output qru_pkg::div_out_t dout
);

  qru_pkg::div_stage_t pre_next;
  qru_pkg::div_stage_t st [qru_pkg::QB+1];
  qru_pkg::div_out_t   dout_next;

  always_comb begin
    logic [qru_pkg::HI_W-1:0] hi;
    pre_next.valid = din.valid;
    pre_next.degen = din.degen;
    pre_next.d     = din.d;
    for (int k = 0; k < 4; k++) begin
      hi                 = din.num[k][qru_pkg::NUM_W-1:qru_pkg::QB];
      // quotient of 2^16 or more always saturates
      pre_next.ovf[k]    = hi >= qru_pkg::HI_W'(din.d);
      pre_next.rem[k]    = pre_next.ovf[k] ? '0 : qru_pkg::D_W'(hi);
      pre_next.lo[k]     = din.num[k][qru_pkg::QB-1:0];
      pre_next.q[k]      = '0;
      pre_next.neg[k]    = din.neg[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0] <= pre_next;
    end
  end

  for (genvar g = 0; g < qru_pkg::QB; g++) begin : g_step
    qru_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (st[g]),
      .dout (st[g+1])
    );
  end

  always_comb begin
    dout_next.valid = st[qru_pkg::QB].valid;
    dout_next.degen = st[qru_pkg::QB].degen;
    dout_next.sat   = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (st[qru_pkg::QB].neg[k]) begin
        if (st[qru_pkg::QB].ovf[k] || (st[qru_pkg::QB].q[k] > qru_pkg::NEG_MAG)) begin
          dout_next.res[k] = qru_pkg::q16_t'(qru_pkg::NEG_MAG);
          dout_next.sat    = 1'b1;
        end else begin
          dout_next.res[k] = qru_pkg::q16_t'(qru_pkg::QB'(0) - st[qru_pkg::QB].q[k]);
        end
      end else begin
        if (st[qru_pkg::QB].ovf[k] || (st[qru_pkg::QB].q[k] > qru_pkg::POS_MAX)) begin
          dout_next.res[k] = qru_pkg::q16_t'(qru_pkg::POS_MAX);
          dout_next.sat    = 1'b1;
        end else begin
          dout_next.res[k] = qru_pkg::q16_t'(st[qru_pkg::QB].q[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

>>> rtl/core/quaternion_rotation_unit_top.sv
// ----------------------------------------------------------------------------
// quaternion_rotation_unit_top
// Throughput: one request per cycle while the skid register is empty; 4 product stages, 18 divider stages.
// A stalled result is parked in a skid register; the pipeline holds while it waits.
// Reset: all valids cleared, min_norm_squared set to 2684.
// ----------------------------------------------------------------------------
`include "quaternion_rotation_unit_top_macros.svh"

module quaternion_rotation_unit_top (
  input logic         clk,
  input logic         rst,
  qru_cfg_if.sink     cfg,
  qru_in_if.sink      item,
  qru_out_if.source   result
);

  logic [qru_pkg::CFG_W-1:0] thr;
  logic                      en;
  qru_pkg::q16_t             rot  [4];
  qru_pkg::q16_t             subj [4];
  qru_pkg::div_in_t          prod_out;
  qru_pkg::div_out_t         div_out;
  qru_pkg::div_out_t         skid;
  qru_pkg::div_out_t         out_sel;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= qru_pkg::MIN_NORM_RESET;
    end else if (cfg.valid) begin
      thr <= cfg.data;
    end
  end

  assign en         = !skid.valid;
  assign item.ready = en;

  assign rot[0]  = item.rot_w;
  assign rot[1]  = item.rot_x;
  assign rot[2]  = item.rot_y;
  assign rot[3]  = item.rot_z;
  assign subj[0] = item.subj_w;
  assign subj[1] = item.subj_x;
  assign subj[2] = item.subj_y;
  assign subj[3] = item.subj_z;

  qru_prod u_prod (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (item.valid),
    .rot      (rot),
    .subj     (subj),
    .thr      (thr),
    .dout     (prod_out)
  );

  qru_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (prod_out),
    .dout (div_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid.valid <= 1'b0;
    end else if (skid.valid) begin
      if (result.ready) begin
        skid.valid <= 1'b0;
      end
    end else if (div_out.valid && !result.ready) begin
      skid <= div_out;
    end
  end

  always_comb begin
    if (skid.valid) begin
      out_sel = skid;
    end else begin
      out_sel = div_out;
    end
  end

  assign result.valid      = out_sel.valid;
  assign result.res_w      = out_sel.res[0];
  assign result.res_x      = out_sel.res[1];
  assign result.res_y      = out_sel.res[2];
  assign result.res_z      = out_sel.res[3];
  assign result.degenerate = out_sel.degen;
  assign result.saturated  = out_sel.sat;

  `QRU_ASSERT_IMPLY(a_skid_blocks_req, skid.valid, !item.ready, "held result must block requests")
  `QRU_ASSERT_IMPLY(a_empty_takes_req, !result.valid, item.ready, "empty output must take requests")
  `QRU_ASSERT_NEXT(a_stall_holds, result.valid && !result.ready, result.valid, "stalled result lost")
  `QRU_ASSERT_NEXT(a_cfg_write, cfg.valid, thr == $past(cfg.data), "threshold write lost")

endmodule
